// ----- sv/assert_macros.svh -----
// Assertion macros shared by the command retransmit queue RTL.
// Depends on signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define CRQ_ASSERT(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define CRQ_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define CRQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- sv/crq_pkg.sv -----
// Package for the command retransmit queue: sizes, codes and shared types.
// No dependencies.
package crq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int DATA_W      = 64;
   localparam int KEY_LSB     = 24;
   localparam int KEY_W       = 8;

   localparam int REQ_TDATA_W = 2 * DATA_W;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 136;
   localparam int RSP_TUSER_W = 3;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int LIMIT_W     = 8;
   localparam logic REG_RETRY_LIMIT             = 1'b0;
   localparam logic [LIMIT_W-1:0] RETRY_LIMIT_RESET = 8'd15;
   localparam logic [LIMIT_W-1:0] RETRY_MAX         = 8'hFF;

   typedef enum logic [1:0] {
      CMD_APPEND = 2'd0,
      CMD_ACK    = 2'd1,
      CMD_TICK   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_RESENT     = 3'd0,
      ST_APPENDED   = 3'd1,
      ST_DUPLICATE  = 3'd2,
      ST_BAD_LENGTH = 3'd3,
      ST_FULL       = 3'd4,
      ST_ACK_OK     = 3'd5,
      ST_ACK_REFUSE = 3'd6,
      ST_TICK_EMPTY = 3'd7
   } status_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

// ----- sv/command_retransmit_queue.sv -----
// Append passes through S_CMP, S_APPEND and S_EMIT before its result is registered;
// an ack removes matching entries in S_ACK, then goes to S_EMIT; a refused ack and a
// tick on an empty queue go straight to S_EMIT. Tick: one resent entry per cycle while
// the output slot is free, over one full rotation of the cell ring, then S_FINISH.
// One command in flight at a time. Reset clears entry count, retry count and the output
// valid flag; retry limit goes to 15. Cell contents are not cleared.
`include "assert_macros.svh"

module command_retransmit_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [crq_pkg::REQ_TDATA_W-1:0] req_tdata,  // data_high, data_low
   input  logic [crq_pkg::REQ_TUSER_W-1:0] req_tuser,  // cmd, full_length
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_high, out_low, head_dropped, entries_left, zero pad
   output logic [crq_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [crq_pkg::RSP_TUSER_W-1:0] rsp_tuser,  // status
   output logic                            rsp_tlast,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [crq_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [crq_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [crq_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import crq_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_CMP    = 7'b0000010,
      S_APPEND = 7'b0000100,
      S_ACK    = 7'b0001000,
      S_RESEND = 7'b0010000,
      S_FINISH = 7'b0100000,
      S_EMIT   = 7'b1000000
   } state_type;

   state_type           state_ff, state_in;
   logic                full_ff, full_in;
   logic [DATA_W-1:0]   high_ff, high_in;
   logic [DATA_W-1:0]   low_ff, low_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [LIMIT_W-1:0]  retry_ff, retry_in;
   logic                drop_ff, drop_in;
   logic [IDX_W-1:0]    step_ff, step_in;
   status_type          status_ff, status_in;

   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff;
   logic [DATA_W-1:0]   rsp_high_ff, rsp_low_ff;
   logic                rsp_drop_ff, rsp_last_ff;
   logic [CNT_W-1:0]    rsp_left_ff;

   logic [LIMIT_W-1:0]  retry_limit;
   logic [LIMIT_W-1:0]  retry_next;
   logic                accept, slot_free;
   cmd_type             req_cmd;

   logic                emit, emit_drop, emit_last;
   status_type          emit_status;
   logic [DATA_W-1:0]   emit_high, emit_low;
   logic [CNT_W-1:0]    emit_left;

   logic                rotate, compact, drop_shift, load;
   logic                any_match, any_dup;
   logic [CNT_W-1:0]    step_ext;

   cell_ctl_type        cell_ctl  [QUEUE_DEPTH];
   logic [DATA_W-1:0]   cell_high [QUEUE_DEPTH];
   logic [DATA_W-1:0]   cell_low  [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] key_hit, full_hit, valid, match, prefix;

   crq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .retry_limit (retry_limit)
   );

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      localparam int NXT = (i + 1) % QUEUE_DEPTH;
      localparam logic [CNT_W-1:0] POS = CNT_W'(i);

      crq_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl[i]),
         .nbr_high  (cell_high[NXT]),
         .nbr_low   (cell_low[NXT]),
         .in_high   (high_ff),
         .in_low    (low_ff),
         .cell_high (cell_high[i]),
         .cell_low  (cell_low[i]),
         .key_hit   (key_hit[i]),
         .full_hit  (full_hit[i])
      );

      assign valid[i]          = POS < count_ff;
      assign match[i]          = valid[i] && key_hit[i];
      assign cell_ctl[i].shift = rotate || drop_shift || (compact && prefix[i]);
      assign cell_ctl[i].load  = load && (count_ff == POS);
   end

   always_comb begin
      prefix[0] = match[0];
      for (int j = 1; j < QUEUE_DEPTH; j++) begin
         prefix[j] = prefix[j-1] | match[j];
      end
   end

   assign any_match  = |match;
   assign any_dup    = |(full_hit & valid);
   assign req_tready = state_ff == S_IDLE;
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_cmd    = cmd_type'(req_tuser[1:0]);
   assign retry_next = (retry_ff == RETRY_MAX) ? RETRY_MAX : retry_ff + 8'd1;
   assign step_ext   = CNT_W'(step_ff);

   always_comb begin
      state_in    = state_ff;
      full_in     = full_ff;
      high_in     = high_ff;
      low_in      = low_ff;
      count_in    = count_ff;
      retry_in    = retry_ff;
      drop_in     = drop_ff;
      step_in     = step_ff;
      status_in   = status_ff;
      emit        = 1'b0;
      emit_status = status_ff;
      emit_high   = '0;
      emit_low    = '0;
      emit_drop   = 1'b0;
      emit_last   = 1'b1;
      emit_left   = count_ff;
      rotate      = 1'b0;
      compact     = 1'b0;
      drop_shift  = 1'b0;
      load        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               full_in = req_tuser[2];
               high_in = req_tdata[DATA_W-1:0];
               low_in  = req_tdata[REQ_TDATA_W-1:DATA_W];
               unique case (req_cmd)
                  CMD_APPEND: state_in = S_CMP;
                  CMD_ACK: begin
                     if (req_tuser[2] && (count_ff != '0)) begin
                        state_in = S_ACK;
                     end else begin
                        status_in = ST_ACK_REFUSE;
                        state_in  = S_EMIT;
                     end
                  end
                  CMD_TICK: begin
                     if (count_ff == '0) begin
                        status_in = ST_TICK_EMPTY;
                        state_in  = S_EMIT;
                     end else begin
                        drop_in  = retry_next > retry_limit;
                        step_in  = '0;
                        state_in = S_RESEND;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_CMP: state_in = S_APPEND;
         S_APPEND: begin
            if (!full_ff) begin
               status_in = ST_BAD_LENGTH;
            end else if (any_dup) begin
               status_in = ST_DUPLICATE;
            end else if (count_ff >= CNT_W'(QUEUE_DEPTH)) begin
               status_in = ST_FULL;
            end else begin
               load      = 1'b1;
               count_in  = CNT_W'(count_ff + 1'b1);
               status_in = ST_APPENDED;
            end
            state_in = S_EMIT;
         end
         S_ACK: begin
            if (any_match) begin
               compact  = 1'b1;
               count_in = CNT_W'(count_ff - 1'b1);
            end else begin
               retry_in  = '0;
               status_in = ST_ACK_OK;
               state_in  = S_EMIT;
            end
         end
         S_RESEND: begin
            if (step_ext < count_ff) begin
               if (slot_free) begin
                  emit        = 1'b1;
                  emit_status = ST_RESENT;
                  emit_high   = cell_high[0];
                  emit_low    = cell_low[0];
                  emit_left   = CNT_W'(count_ff - CNT_W'(drop_ff));
                  emit_last   = step_ext == CNT_W'(count_ff - 1'b1);
                  emit_drop   = emit_last && drop_ff;
                  rotate      = 1'b1;
               end
            end else begin
               rotate = 1'b1;
            end
            if (rotate) begin
               step_in = IDX_W'(step_ff + 1'b1);
               if (step_ff == IDX_W'(QUEUE_DEPTH - 1)) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            retry_in = retry_next;
            if (drop_ff) begin
               drop_shift = 1'b1;
               count_in   = CNT_W'(count_ff - 1'b1);
               retry_in   = '0;
            end
            state_in = S_IDLE;
         end
         S_EMIT: begin
            if (slot_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         retry_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         retry_ff     <= retry_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      full_ff   <= full_in;
      high_ff   <= high_in;
      low_ff    <= low_in;
      drop_ff   <= drop_in;
      step_ff   <= step_in;
      status_ff <= status_in;
      if (emit) begin
         rsp_status_ff <= emit_status;
         rsp_high_ff   <= emit_high;
         rsp_low_ff    <= emit_low;
         rsp_drop_ff   <= emit_drop;
         rsp_left_ff   <= emit_left;
         rsp_last_ff   <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - 2 * DATA_W - 1 - CNT_W){1'b0}},
                        rsp_left_ff, rsp_drop_ff, rsp_low_ff, rsp_high_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   `CRQ_ASSERT(a_count_bound, count_ff <= CNT_W'(QUEUE_DEPTH))
   `CRQ_ASSERT_IMPL(a_drop_on_last, emit && emit_drop, emit_last)
   `CRQ_ASSERT_NEXT(a_ack_shrink, state_ff == S_ACK && any_match,
                    count_ff == CNT_W'($past(count_ff) - 1'b1))
   `CRQ_ASSERT_IMPL(a_emit_slot, emit, slot_free)

endmodule

// ----- sv/crq_cell.sv -----
// One queue cell: holds a 16-byte command, takes its right neighbor's entry
// on shift or the pending command on load, and compares against it.
// Depends on crq_pkg.
module crq_cell (
   input  logic                       clock,
   input  crq_pkg::cell_ctl_type      ctl,
   input  logic [crq_pkg::DATA_W-1:0] nbr_high,
   input  logic [crq_pkg::DATA_W-1:0] nbr_low,
   input  logic [crq_pkg::DATA_W-1:0] in_high,
   input  logic [crq_pkg::DATA_W-1:0] in_low,
   output logic [crq_pkg::DATA_W-1:0] cell_high,
   output logic [crq_pkg::DATA_W-1:0] cell_low,
   output logic                       key_hit,
   output logic                       full_hit
);
   import crq_pkg::*;

   logic [DATA_W-1:0] high_ff, high_in;
   logic [DATA_W-1:0] low_ff, low_in;
   logic              hit_ff, hit_in;

   always_comb begin
      high_in = high_ff;
      low_in  = low_ff;
      if (ctl.load) begin
         high_in = in_high;
         low_in  = in_low;
      end else if (ctl.shift) begin
         high_in = nbr_high;
         low_in  = nbr_low;
      end
      hit_in = (high_ff == in_high) && (low_ff == in_low);
   end

   always_ff @(posedge clock) begin
      high_ff <= high_in;
      low_ff  <= low_in;
      hit_ff  <= hit_in;
   end

   assign cell_high = high_ff;
   assign cell_low  = low_ff;
   assign key_hit   = high_ff[KEY_LSB +: KEY_W] == in_high[KEY_LSB +: KEY_W];
   assign full_hit  = hit_ff;

endmodule

// ----- sv/crq_csr.sv -----
// Configuration register file: retry limit behind an APB-style port.
// Depends on crq_pkg.
module crq_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [crq_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [crq_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [crq_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output logic [crq_pkg::LIMIT_W-1:0]    retry_limit
);
   import crq_pkg::*;

   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               reg_idx;
   logic               wr_en;

   assign reg_idx = csr_paddr[CSR_ADDR_W-1];
   assign wr_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      limit_in = limit_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_RETRY_LIMIT: limit_in = csr_pwdata[LIMIT_W-1:0];
            default:         limit_in = limit_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= RETRY_LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_RETRY_LIMIT: csr_prdata = {{(CSR_DATA_W - LIMIT_W){1'b0}}, limit_ff};
         default:         csr_prdata = '0;
      endcase
   end

   assign csr_pready  = 1'b1;
   assign retry_limit = limit_ff;

endmodule

// ----- tb/command_retransmit_queue_tb.sv -----
// Self-checking testbench for command_retransmit_queue: streams append, ack and tick
// commands, predicts every reply from a behavioral copy of the queue and checks them.
// Depends on crq_pkg and the command_retransmit_queue RTL.
module command_retransmit_queue_tb;
   import crq_pkg::*;

   localparam int TIMEOUT_CYCLES = 400000;
   localparam int SETTLE_CYCLES  = 64;
   localparam int REPORT_MAX     = 10;
   localparam logic [CSR_ADDR_W-1:0] LIMIT_ADDR =
      CSR_ADDR_W'(int'(REG_RETRY_LIMIT) * 4);

   typedef struct packed {
      cmd_type     cmd;
      logic        full;
      logic [63:0] high;
      logic [63:0] low;
   } command_item;

   typedef struct packed {
      status_type  status;
      logic [63:0] high;
      logic [63:0] low;
      logic        dropped;
      logic [4:0]  left;
      logic        last;
   } queue_reply;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // data_high, data_low
   logic [REQ_TUSER_W-1:0] req_tuser;   // cmd, full_length
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // out_high, out_low, head_dropped, entries_left, zero pad
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;   // status
   logic                   rsp_tlast;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   command_item    outgoing_cmds[$];
   queue_reply     expected_replies[$];
   logic [127:0]   recent_cmds[$];
   logic [63:0]    stored_high[$];
   logic [63:0]    stored_low[$];
   logic [7:0]     retry_count_model;
   logic [7:0]     retry_limit_model;
   logic           req_taken;
   logic [31:0]    cycle_count;
   logic           steady;
   int             error_count;
   int             replies_checked;
   int             heads_dropped;
   int             cmd_seen[4];

   command_retransmit_queue u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // long stretches with no idling on either side
   assign steady = (cycle_count[11:10] == 2'b00);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == TIMEOUT_CYCLES) begin
         $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
                  expected_replies.size());
         $display("command_retransmit_queue_tb: FAIL");
         $finish;
      end
   end

   task automatic predict_replies(input command_item c);
      queue_reply  r;
      logic [63:0] keep_high[$];
      logic [63:0] keep_low[$];
      logic        dup;
      logic        drop;
      int          n;
      r = '0;
      r.last = 1'b1;
      case (c.cmd)
         CMD_APPEND: begin
            dup = 1'b0;
            foreach (stored_high[i])
               if (stored_high[i] == c.high && stored_low[i] == c.low) dup = 1'b1;
            if (!c.full) r.status = ST_BAD_LENGTH;
            else if (dup) r.status = ST_DUPLICATE;
            else if (stored_high.size() >= QUEUE_DEPTH) r.status = ST_FULL;
            else begin
               stored_high.push_back(c.high);
               stored_low.push_back(c.low);
               r.status = ST_APPENDED;
            end
            r.left = 5'(stored_high.size());
            expected_replies.push_back(r);
         end
         CMD_ACK: begin
            r.status = ST_ACK_REFUSE;
            if (c.full && stored_high.size() != 0) begin
               foreach (stored_high[i])
                  if (stored_high[i][31:24] != c.high[31:24]) begin
                     keep_high.push_back(stored_high[i]);
                     keep_low.push_back(stored_low[i]);
                  end
               stored_high = keep_high;
               stored_low = keep_low;
               retry_count_model = 8'd0;
               r.status = ST_ACK_OK;
            end
            r.left = 5'(stored_high.size());
            expected_replies.push_back(r);
         end
         CMD_TICK: begin
            n = stored_high.size();
            if (n == 0) begin
               r.status = ST_TICK_EMPTY;
               expected_replies.push_back(r);
            end else begin
               if (retry_count_model != RETRY_MAX) retry_count_model = retry_count_model + 1;
               drop = (retry_count_model > retry_limit_model);
               if (drop) begin
                  retry_count_model = 8'd0;
                  heads_dropped++;
               end
               for (int i = 0; i < n; i++) begin
                  r.status = ST_RESENT;
                  r.high = stored_high[i];
                  r.low = stored_low[i];
                  r.left = 5'(n - int'(drop));
                  r.last = (i == n - 1);
                  r.dropped = (i == n - 1) && drop;
                  expected_replies.push_back(r);
               end
               if (drop) begin
                  void'(stored_high.pop_front());
                  void'(stored_low.pop_front());
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string what, input queue_reply want,
                                  input queue_reply got);
      error_count++;
      if (error_count <= REPORT_MAX) begin
         $display("mismatch (%s) at cycle %0d", what, cycle_count);
         $display("  expected status %0d high %h low %h dropped %b left %0d last %b",
                  want.status, want.high, want.low, want.dropped, want.left, want.last);
         $display("  actual   status %0d high %h low %h dropped %b left %0d last %b",
                  got.status, got.high, got.low, got.dropped, got.left, got.last);
      end
   endtask

   always @(posedge clock) begin : watch_ports
      queue_reply  got;
      queue_reply  want;
      command_item c;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            got.status  = status_type'(rsp_tuser);
            got.high    = rsp_tdata[63:0];
            got.low     = rsp_tdata[127:64];
            got.dropped = rsp_tdata[128];
            got.left    = rsp_tdata[133:129];
            got.last    = rsp_tlast;
            if (expected_replies.size() == 0) begin
               report_mismatch("reply with none expected", '0, got);
            end else begin
               want = expected_replies.pop_front();
               replies_checked++;
               if (got !== want) report_mismatch("reply fields", want, got);
            end
         end
         if (req_tvalid && req_tready) begin
            c.cmd  = cmd_type'(req_tuser[1:0]);
            c.full = req_tuser[2];
            c.high = req_tdata[63:0];
            c.low  = req_tdata[127:64];
            cmd_seen[c.cmd]++;
            predict_replies(c);
         end
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite && csr_paddr == LIMIT_ADDR) begin
               retry_limit_model <= csr_pwdata[7:0];
            end else if (!csr_pwrite && csr_prdata !== {24'd0, retry_limit_model}) begin
               error_count++;
               if (error_count <= REPORT_MAX)
                  $display("retry limit readback: expected %h actual %h",
                           {24'd0, retry_limit_model}, csr_prdata);
            end
         end
      end
   end

   always @(negedge clock) begin : drive_ports
      command_item c;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(0, 99) >= 25);
         if (!req_tvalid || req_taken) begin
            if (outgoing_cmds.size() != 0 && (steady || $urandom_range(0, 99) >= 25)) begin
               c = outgoing_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {c.low, c.high};
               req_tuser  <= {c.full, c.cmd};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic add_cmd(input cmd_type cmd, input logic full, input logic [63:0] high,
                          input logic [63:0] low);
      command_item c;
      c.cmd = cmd;
      c.full = full;
      c.high = high;
      c.low = low;
      outgoing_cmds.push_back(c);
   endtask

   task automatic add_random(input int count, input int append_pct, input int ack_pct,
                             input int tick_pct);
      command_item  c;
      logic [127:0] pick;
      int           roll;
      for (int k = 0; k < count; k++) begin
         roll = $urandom_range(0, 99);
         c.full = ($urandom_range(0, 99) >= 12);
         c.high = {$urandom, $urandom};
         c.low = {$urandom, $urandom};
         if (recent_cmds.size() != 0)
            pick = recent_cmds[$urandom_range(0, recent_cmds.size() - 1)];
         else
            pick = '0;
         if (roll < append_pct) begin
            c.cmd = CMD_APPEND;
            if (recent_cmds.size() != 0 && $urandom_range(0, 99) < 15) begin
               c.high = pick[63:0];
               c.low = pick[127:64];
            end else begin
               if ($urandom_range(0, 99) < 70) c.high[31:24] = 8'($urandom_range(0, 3));
               if (c.full) recent_cmds.push_back({c.low, c.high});
               if (recent_cmds.size() > 24) void'(recent_cmds.pop_front());
            end
         end else if (roll < append_pct + ack_pct) begin
            c.cmd = CMD_ACK;
            if (recent_cmds.size() != 0 && $urandom_range(0, 99) < 60)
               c.high[31:24] = pick[31:24];
         end else if (roll < append_pct + ack_pct + tick_pct) begin
            c.cmd = CMD_TICK;
         end else begin
            c.cmd = CMD_NONE;
         end
         outgoing_cmds.push_back(c);
      end
   endtask

   task automatic wait_idle();
      while (outgoing_cmds.size() != 0 || req_tvalid || expected_replies.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_retry_limit(input logic [7:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= LIMIT_ADDR;
      csr_pwdata  <= {24'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      reset             = 1'b1;
      req_tvalid        = 1'b0;
      req_tdata         = '0;
      req_tuser         = '0;
      rsp_tready        = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      req_taken         = 1'b0;
      cycle_count       = '0;
      retry_count_model = 8'd0;
      retry_limit_model = RETRY_LIMIT_RESET;
      error_count       = 0;
      replies_checked   = 0;
      heads_dropped     = 0;
      cmd_seen          = '{default: 0};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_cmd(CMD_TICK, 1'b1, '1, '0);
      add_cmd(CMD_ACK, 1'b1, 64'h0000_0000_FF00_0000, '0);
      add_cmd(CMD_APPEND, 1'b0, '1, '1);
      add_cmd(CMD_APPEND, 1'b1, '0, '0);
      add_cmd(CMD_APPEND, 1'b1, '1, '1);
      add_cmd(CMD_ACK, 1'b0, '1, '1);
      add_cmd(CMD_TICK, 1'b0, {$urandom, $urandom}, {$urandom, $urandom});
      add_cmd(CMD_NONE, 1'b1, {$urandom, $urandom}, {$urandom, $urandom});
      add_cmd(CMD_ACK, 1'b1, 64'hFFFF_FFFF_5AFF_FFFF, '1);
      for (int i = 0; i < QUEUE_DEPTH - 2; i++)
         add_cmd(CMD_APPEND, 1'b1, {$urandom, 8'(8'h10 + i), 24'($urandom)},
                 {$urandom, $urandom});
      add_cmd(CMD_APPEND, 1'b1, {$urandom, 8'h7E, 24'($urandom)}, {$urandom, $urandom});
      add_cmd(CMD_APPEND, 1'b1, '0, '0);
      add_cmd(CMD_TICK, 1'b1, '0, '0);
      add_cmd(CMD_ACK, 1'b1, 64'h0000_0000_FF00_0000, {$urandom, $urandom});
      wait_idle();

      set_retry_limit(8'd0);
      add_random(10, 50, 15, 30);
      wait_idle();

      // hold the queue non-empty with no acks until the retry count saturates
      set_retry_limit(8'hFF);
      for (int i = 0; i < 3; i++)
         add_cmd(CMD_APPEND, 1'b1, {$urandom, $urandom}, {$urandom, $urandom});
      for (int i = 0; i < 258; i++)
         add_cmd(CMD_TICK, 1'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
      wait_idle();
      set_retry_limit(8'hFE);
      add_cmd(CMD_TICK, 1'b1, '0, '0);
      add_cmd(CMD_TICK, 1'b1, '0, '0);
      wait_idle();

      set_retry_limit(8'd2);
      add_random(8, 60, 10, 25);
      wait_idle();

      set_retry_limit(8'($urandom_range(1, 8)));
      add_random(8, 40, 30, 25);
      wait_idle();

      $display("covered %0d appends, %0d acks, %0d ticks, %0d unknown commands",
               cmd_seen[CMD_APPEND], cmd_seen[CMD_ACK], cmd_seen[CMD_TICK],
               cmd_seen[CMD_NONE]);
      $display("checked %0d replies, %0d head drops, %0d errors",
               replies_checked, heads_dropped, error_count + expected_replies.size());
      if (error_count == 0 && expected_replies.size() == 0) begin
         $display("command_retransmit_queue_tb: PASS");
      end else begin
         $display("command_retransmit_queue_tb: FAIL");
      end
      $finish;
   end

endmodule
